FILE: design/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg: shared types and constants of the free-list heap allocator
// Operation codes, status codes, register indexes and the command word that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package fla_pkg;

  localparam int unsigned OFS_W  = 16;  // byte offset within the heap
  localparam int unsigned SPAN_W = 17;  // extent or block length in bytes
  localparam int unsigned EXT_W  = OFS_W + SPAN_W;
  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned SPLIT_MIN = 16;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_BAD_PTR    = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REG_REGION = 1'b0;
  localparam logic REG_FIT    = 1'b1;

  localparam logic KIND_ALLOC = 1'b0;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_NULL,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SPAN_W-1:0] need;  // block bytes with header, allocate only
    logic [OFS_W-1:0]  hdr;   // header offset, free only
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/free_list_heap_allocator.sv
// ----------------------------------------------------------------------------
// free_list_heap_allocator: heap allocator over a sorted free-extent table
// Front end classifies requests into a two-word queue; back end walks the
// extent table held in RAM, splits or merges extents and keeps block marks.
// ----------------------------------------------------------------------------
// Path, accept to result valid: a null or bad free goes straight to the result;
//   an allocate walks every extent, then closes the gap of a whole-extent take;
//   a free reads its mark, scans to its place, then shifts the tail of an insert
//   or three-way merge. Flow: one item at a time (extent RAM walk).
// Reset: a clearing pass over all MarkDepth entries (8192 by default) zeroes the
//   block marks and rebuilds one free extent; a region write reruns it.
`default_nettype none

module free_list_heap_allocator #(
  parameter int unsigned PAGE_BYTES  = 4096,
  parameter int unsigned MAX_PAGES   = 16,
  parameter int unsigned MAX_EXTENTS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [4:0]  cfg_wdata_i,
  // request words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [15:0] request_size_i,
  input  wire logic [15:0] user_offset_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      block_offset_o,
  output logic [1:0]       status_o
);
  import fla_pkg::*;

  // One mark per 8-byte granule of the largest region.
  localparam int unsigned MarkDepth = PAGE_BYTES * MAX_PAGES / 8;

  logic busy;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Front: take request words, round sizes, screen null and bad frees.
  fla_front #(.MarkDepth(MarkDepth)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .request_size_i (request_size_i),
    .user_offset_i  (user_offset_i),
    .busy_i         (busy),
    .cmd_pop_i      (cmd_pop),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd)
  );

  // Back: walk, split, merge and shift the extent table; hold the result
  // word in an output register so the next command can start meanwhile.
  fla_back #(
    .PageBytes  (PAGE_BYTES),
    .MaxPages   (MAX_PAGES),
    .MaxExtents (MAX_EXTENTS),
    .MarkDepth  (MarkDepth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_offset_o (block_offset_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

FILE: design/fla_ram.sv
// ----------------------------------------------------------------------------
// fla_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/fla_front.sv
// ----------------------------------------------------------------------------
// fla_front: request intake and classification
// Accept request words, size allocations, screen frees, queue two commands.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_front #(
  parameter int unsigned MarkDepth = 8192
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  kind_i,
  input  wire logic [15:0]           request_size_i,
  input  wire logic [15:0]           user_offset_i,
  input  wire logic                  busy_i,
  input  wire logic                  cmd_pop_i,
  output logic                       cmd_valid_o,
  output fla_pkg::cmd_t              cmd_o
);
  import fla_pkg::*;

  cmd_t              cmd_in;
  logic [SPAN_W-1:0] rounded;
  logic [OFS_W-1:0]  hdr;
  logic              push;
  cmd_t              q_mem [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  // Round up to 8, add the header.
  assign rounded = ({1'b0, request_size_i} + SPAN_W'(7)) & ~SPAN_W'(7);
  assign hdr     = user_offset_i - OFS_W'(HDR_BYTES);

  always_comb begin
    cmd_in.need = rounded + SPAN_W'(HDR_BYTES);
    cmd_in.hdr  = hdr;
    if (kind_i == KIND_ALLOC) begin
      cmd_in.op = OP_ALLOC;
    end else if (user_offset_i == '0) begin
      cmd_in.op = OP_NULL;
    end else if (user_offset_i < OFS_W'(HDR_BYTES) || user_offset_i[2:0] != 3'd0) begin
      cmd_in.op = OP_BAD;
    end else if ({3'b000, hdr[15:3]} >= 16'(MarkDepth)) begin
      cmd_in.op = OP_BAD;  // header lies past any markable granule
    end else begin
      cmd_in.op = OP_FREE;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2) && !busy_i;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

`default_nettype wire

FILE: design/fla_back.sv
// ----------------------------------------------------------------------------
// fla_back: allocation engine
// Walk the extent table, split, merge and shift entries, keep block marks.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_back #(
  parameter int unsigned PageBytes  = 4096,
  parameter int unsigned MaxPages   = 16,
  parameter int unsigned MaxExtents = 32,
  parameter int unsigned MarkDepth  = 8192
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_index_i,
  input  wire logic [4:0]     cfg_wdata_i,
  input  wire logic           cmd_valid_i,
  input  wire fla_pkg::cmd_t  cmd_i,
  output logic                cmd_pop_o,
  output logic                busy_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [15:0]         block_offset_o,
  output logic [1:0]          status_o
);
  import fla_pkg::*;

  localparam int unsigned IW  = (MaxExtents > 1) ? $clog2(MaxExtents) : 1;
  localparam int unsigned CW  = $clog2(MaxExtents + 1);
  localparam int unsigned MAW = (MarkDepth > 1) ? $clog2(MarkDepth) : 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ASCAN, S_ACOMMIT, S_FMARK, S_FSCAN, S_FDECIDE,
    S_DROP, S_INS, S_DONE
  } state_e;

  state_e            state_q;
  logic [4:0]        region_q;
  logic [1:0]        fit_q;
  logic [MAW-1:0]    clr_q;
  logic [CW-1:0]     count_q, idx_q, pos_q;
  logic              pend_q;
  logic [IW-1:0]     pend_idx_q;
  cmd_t              cmd_q;
  logic              sel_found_q;
  logic [IW-1:0]     sel_idx_q;
  logic [OFS_W-1:0]  sel_start_q, prev_start_q, hi_start_q;
  logic [SPAN_W-1:0] sel_span_q, prev_span_q, hi_span_q, size_q;
  logic              prev_valid_q, hi_valid_q;
  logic [OFS_W-1:0]  res_offset_q;
  logic [1:0]        res_status_q;
  logic              out_valid_q;
  logic [15:0]       out_offset_q;
  logic [1:0]        out_status_q;

  // RAM ports
  logic              ext_we;
  logic [IW-1:0]     ext_waddr, ext_raddr;
  logic [EXT_W-1:0]  ext_wdata, ext_rdata;
  logic              mark_we;
  logic [MAW-1:0]    mark_waddr, mark_raddr;
  logic [SPAN_W-1:0] mark_wdata, mark_rdata;

  // Decode helpers
  logic [4:0]        pages;
  logic [SPAN_W-1:0] region_bytes;
  logic [OFS_W-1:0]  e_start;
  logic [SPAN_W-1:0] e_span;
  logic              e_take;
  logic [SPAN_W-1:0] rem;
  logic              do_split;
  logic [17:0]       prev_end, hdr_end;
  logic              join_lo, join_hi;
  logic              out_free;

  assign pages = (region_q == 5'd0) ? 5'd1 :
                 (region_q > 5'(MaxPages)) ? 5'(MaxPages) : region_q;
  assign region_bytes = SPAN_W'(32'(pages) * PageBytes);

  assign e_span  = ext_rdata[SPAN_W-1:0];
  assign e_start = ext_rdata[EXT_W-1 -: OFS_W];

  // Fit test of the entry now on the read port
  always_comb begin
    e_take = 1'b0;
    if (e_span >= cmd_q.need) begin
      if (!sel_found_q) begin
        e_take = 1'b1;
      end else if (fit_q == FIT_BEST && e_span < sel_span_q) begin
        e_take = 1'b1;
      end else if (fit_q == FIT_WORST && e_span > sel_span_q) begin
        e_take = 1'b1;
      end
    end
  end

  assign rem      = sel_span_q - cmd_q.need;
  assign do_split = rem > SPAN_W'(SPLIT_MIN);
  assign prev_end = {2'b00, prev_start_q} + {1'b0, prev_span_q};
  assign hdr_end  = {2'b00, cmd_q.hdr} + {1'b0, size_q};
  assign join_lo  = prev_valid_q && (prev_end == {2'b00, cmd_q.hdr});
  assign join_hi  = hi_valid_q && (hdr_end == {2'b00, hi_start_q});
  assign out_free = !out_valid_q || out_ready_i;

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign busy_o    = (state_q == S_INIT);

  // RAM port steering
  always_comb begin
    ext_we     = 1'b0;
    ext_waddr  = '0;
    ext_wdata  = '0;
    ext_raddr  = idx_q[IW-1:0];
    mark_we    = 1'b0;
    mark_waddr = cmd_q.hdr[3 +: MAW];
    mark_wdata = '0;
    mark_raddr = cmd_i.hdr[3 +: MAW];
    unique case (state_q)
      S_INIT: begin
        mark_we    = 1'b1;
        mark_waddr = clr_q;
        ext_we     = 1'b1;
        ext_wdata  = {OFS_W'(0), region_bytes};
      end
      S_ACOMMIT: begin
        if (sel_found_q) begin
          mark_we    = 1'b1;
          mark_waddr = sel_start_q[3 +: MAW];
          mark_wdata = do_split ? cmd_q.need : sel_span_q;
          ext_we     = do_split;
          ext_waddr  = sel_idx_q;
          ext_wdata  = {sel_start_q + cmd_q.need[OFS_W-1:0], rem};
        end
      end
      S_FDECIDE: begin
        mark_we = join_lo || join_hi;
        if (join_lo) begin
          ext_we    = 1'b1;
          ext_waddr = IW'(pos_q - CW'(1));
          ext_wdata = join_hi ? {prev_start_q, prev_span_q + size_q + hi_span_q}
                              : {prev_start_q, prev_span_q + size_q};
        end else if (join_hi) begin
          ext_we    = 1'b1;
          ext_waddr = IW'(pos_q);
          ext_wdata = {cmd_q.hdr, hi_span_q + size_q};
        end
      end
      S_DROP: begin
        ext_we    = pend_q;
        ext_waddr = pend_idx_q - IW'(1);
        ext_wdata = ext_rdata;
      end
      S_INS: begin
        ext_raddr = IW'(idx_q - CW'(1));
        if (pend_q) begin
          ext_we    = 1'b1;
          ext_waddr = pend_idx_q + IW'(1);
          ext_wdata = ext_rdata;
        end else if (idx_q <= pos_q) begin
          ext_we    = 1'b1;
          ext_waddr = IW'(pos_q);
          ext_wdata = {cmd_q.hdr, size_q};
          mark_we   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      region_q     <= 5'd16;
      fit_q        <= FIT_FIRST;
      clr_q        <= '0;
      count_q      <= CW'(1);
      idx_q        <= '0;
      pos_q        <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      sel_found_q  <= 1'b0;
      sel_idx_q    <= '0;
      sel_start_q  <= '0;
      sel_span_q   <= '0;
      prev_valid_q <= 1'b0;
      prev_start_q <= '0;
      prev_span_q  <= '0;
      hi_valid_q   <= 1'b0;
      hi_start_q   <= '0;
      hi_span_q    <= '0;
      size_q       <= '0;
      res_offset_q <= '0;
      res_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
      out_offset_q <= '0;
      out_status_q <= ST_OK;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          count_q <= CW'(1);
          clr_q   <= clr_q + MAW'(1);
          if (clr_q == MAW'(MarkDepth - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          idx_q        <= '0;
          pend_q       <= 1'b0;
          sel_found_q  <= 1'b0;
          prev_valid_q <= 1'b0;
          hi_valid_q   <= 1'b0;
          res_offset_q <= '0;
          if (cmd_valid_i) begin
            unique case (cmd_i.op)
              OP_ALLOC: state_q <= S_ASCAN;
              OP_FREE:  state_q <= S_FMARK;
              OP_NULL: begin
                res_status_q <= ST_OK;
                state_q      <= S_DONE;
              end
              default: begin
                res_status_q <= ST_BAD_PTR;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_ASCAN: begin
          pend_q     <= idx_q < count_q;
          pend_idx_q <= idx_q[IW-1:0];
          if (idx_q < count_q) begin
            idx_q <= idx_q + CW'(1);
          end
          if (pend_q && e_take) begin
            sel_found_q <= 1'b1;
            sel_idx_q   <= pend_idx_q;
            sel_start_q <= e_start;
            sel_span_q  <= e_span;
          end
          if (!pend_q && idx_q >= count_q) begin
            state_q <= S_ACOMMIT;
          end
        end
        S_ACOMMIT: begin
          if (!sel_found_q) begin
            res_status_q <= ST_NO_SPACE;
            state_q      <= S_DONE;
          end else begin
            res_status_q <= ST_OK;
            res_offset_q <= sel_start_q + OFS_W'(HDR_BYTES);
            if (do_split) begin
              state_q <= S_DONE;
            end else begin
              idx_q   <= CW'(sel_idx_q) + CW'(1);
              pend_q  <= 1'b0;
              state_q <= S_DROP;
            end
          end
        end
        S_FMARK: begin
          size_q <= mark_rdata;
          if (mark_rdata == '0) begin
            res_status_q <= ST_BAD_PTR;
            state_q      <= S_DONE;
          end else begin
            state_q <= S_FSCAN;
          end
        end
        S_FSCAN: begin
          pend_q     <= idx_q < count_q;
          pend_idx_q <= idx_q[IW-1:0];
          if (idx_q < count_q) begin
            idx_q <= idx_q + CW'(1);
          end
          if (pend_q) begin
            if (e_start < cmd_q.hdr) begin
              prev_valid_q <= 1'b1;
              prev_start_q <= e_start;
              prev_span_q  <= e_span;
            end else begin
              pos_q      <= CW'(pend_idx_q);
              hi_valid_q <= 1'b1;
              hi_start_q <= e_start;
              hi_span_q  <= e_span;
              state_q    <= S_FDECIDE;
            end
          end else if (idx_q >= count_q) begin
            pos_q   <= count_q;
            state_q <= S_FDECIDE;
          end
        end
        S_FDECIDE: begin
          res_status_q <= ST_OK;
          pend_q       <= 1'b0;
          if (join_lo && join_hi) begin
            idx_q   <= pos_q + CW'(1);
            state_q <= S_DROP;
          end else if (join_lo || join_hi) begin
            state_q <= S_DONE;
          end else if (count_q >= CW'(MaxExtents)) begin
            res_status_q <= ST_TABLE_FULL;
            state_q      <= S_DONE;
          end else begin
            idx_q   <= count_q;
            state_q <= S_INS;
          end
        end
        S_DROP: begin
          // Move entry idx down one place, one per cycle
          pend_q     <= idx_q < count_q;
          pend_idx_q <= idx_q[IW-1:0];
          if (idx_q < count_q) begin
            idx_q <= idx_q + CW'(1);
          end
          if (!pend_q && idx_q >= count_q) begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end
        end
        S_INS: begin
          // Move entry idx-1 up one place, from the tail down to pos
          pend_q     <= idx_q > pos_q;
          pend_idx_q <= IW'(idx_q - CW'(1));
          if (idx_q > pos_q) begin
            idx_q <= idx_q - CW'(1);
          end
          if (!pend_q && idx_q <= pos_q) begin
            count_q <= count_q + CW'(1);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_offset_q <= res_offset_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        if (cfg_index_i == REG_REGION) begin
          region_q <= cfg_wdata_i;
          clr_q    <= '0;
          state_q  <= S_INIT;
        end else begin
          fit_q <= cfg_wdata_i[1:0];
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_offset_o = out_offset_q;
  assign status_o       = out_status_q;

  fla_ram #(.Width(EXT_W), .Depth(MaxExtents)) u_ext_ram (
    .clk_i   (clk_i),
    .we_i    (ext_we),
    .waddr_i (ext_waddr),
    .wdata_i (ext_wdata),
    .raddr_i (ext_raddr),
    .rdata_o (ext_rdata)
  );

  fla_ram #(.Width(SPAN_W), .Depth(MarkDepth)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxExtents))
    else $error("extent count beyond table size");

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !cmd_pop_o)
    else $error("command taken during clearing pass");

  a_scan_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ASCAN && !cfg_we_i) |=> $stable(count_q))
    else $error("extent count moved during allocate walk");

endmodule

`default_nettype wire
